// ----- rtl/cwenv_pkg.sv -----
// Package for the CW keying envelope detector.
// Register indexes, reset values, per-channel control word and level pair types.
// No dependencies.
`default_nettype none
package cwenv_pkg;

	localparam int DEF_CHANNELS = 1024;

	localparam int CH_W    = 10;
	localparam int MAG_W   = 24;
	localparam int SNR_W   = 16;
	localparam int CNT_W   = 12;
	localparam int LVL_W   = 32;
	localparam int CFG_W   = 32;
	localparam int CIDX_W  = 3;

	localparam logic [CIDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CIDX_W-1:0] REG_SILENCE   = 3'd1;
	localparam logic [CIDX_W-1:0] REG_UPPER     = 3'd2;
	localparam logic [CIDX_W-1:0] REG_LOWER     = 3'd3;
	localparam logic [CIDX_W-1:0] REG_ATTACK    = 3'd4;
	localparam logic [CIDX_W-1:0] REG_DECAY     = 3'd5;
	localparam logic [CIDX_W-1:0] REG_IDLE      = 3'd6;

	localparam logic [7:0]       RST_THRESHOLD = 8'd64;
	localparam logic [CNT_W-1:0] RST_SILENCE   = 12'd1920;
	localparam logic [7:0]       RST_UPPER     = 8'd154;
	localparam logic [7:0]       RST_LOWER     = 8'd102;
	localparam logic [15:0]      RST_ATTACK    = 16'd6554;
	localparam logic [15:0]      RST_DECAY     = 16'd66;
	localparam logic [LVL_W-1:0] RST_IDLE      = 32'd128;

	// SNR fall gain, 0.05 in Q0.16
	localparam logic [11:0] SNR_FALL = 12'd3277;

	typedef struct packed {
		logic             env;
		logic [SNR_W-1:0] snr;
		logic [CNT_W-1:0] cnt;
		logic             started;
	} ctrl_t;

	typedef struct packed {
		logic [LVL_W-1:0] lo;
		logic [LVL_W-1:0] hi;
	} levels_t;

endpackage
`default_nettype wire

// ----- rtl/cwenv_ram.sv -----
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module cwenv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- rtl/cw_keying_envelope_detector_top.sv -----
// CW keying envelope detector, top level. Uses cwenv_pkg and cwenv_ram.
// Per-channel state sits in two synchronous RAMs (levels and control word).
`default_nettype none
// One item per spectral bin (channel, magnitude, noise floor) gives one result:
// keyed flag, hysteresis envelope bit, smoothed SNR (Q8.8) and the started and
// silence-reset flags. Items are handled one at a time. From input transfer to
// result, the RAM read overlaps the transfer edge, then the radix-4 divider
// forms magnitude*256/noise_floor, followed by three arithmetic steps and a
// write-back state that also loads the output register. The next input
// transfer can come in the cycle after the result is loaded; a result left
// waiting in the output register holds the write-back state, and with it the
// input, until it is taken. A finished result waits in the output register
// while the next item is already accepted. After reset the control RAM is
// swept to zero, one channel per cycle, so no item is accepted until every
// channel has been cleared; configuration writes are taken throughout. Level
// RAM contents are only read once the channel has started, which always
// follows a write of them. Configuration must only be written while the
// block is idle. Channels at or above CHANNELS touch no state and return
// zeros beside the echoed index.
module cw_keying_envelope_detector_top #(
	parameter int CHANNELS = cwenv_pkg::DEF_CHANNELS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [cwenv_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [cwenv_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [cwenv_pkg::CH_W-1:0]   channel,
	input  wire logic [cwenv_pkg::MAG_W-1:0]  magnitude,
	input  wire logic [cwenv_pkg::MAG_W-1:0]  noise_floor,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [cwenv_pkg::CH_W-1:0]   channel_out,
	output logic                             keyed,
	output logic                             envelope,
	output logic      [cwenv_pkg::SNR_W-1:0]  snr_level,
	output logic                             started,
	output logic                             silence_reset
);
	import cwenv_pkg::*;

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_DIV, ST_C1, ST_C2, ST_C3, ST_OUT
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_q;
	logic [3:0]    div_cnt_q;
	logic          out_valid_q;

	// configuration
	logic [7:0]       thr_q, upf_q, lof_q;
	logic [CNT_W-1:0] sil_q;
	logic [15:0]      att_q, dcy_q;
	logic [LVL_W-1:0] idle_q;

	// item registers
	logic [CH_W-1:0]  ch_q;
	logic [MAG_W-1:0] mag_q, nf_q;
	logic [24:0]      rem_q;
	logic [31:0]      quo_q;

	logic [SNR_W-1:0] snr_s1;
	logic             keyed_s1, start_s1, sres_s1, inr_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic [LVL_W-1:0] lo_s1, hi_s1;
	logic [32:0]      rng_s1;
	logic             env_old_s1;

	logic [LVL_W-1:0] upo_s2, dno_s2, dec_s2, dlo_s2, dhi_s2;
	logic             plo_s2, phi_s2;

	logic [LVL_W-1:0] alo_s3, ahi_s3;
	logic             env_s3;

	logic [CH_W-1:0]  ch_out_q;
	logic             keyed_q, env_q, start_q, sres_q;
	logic [SNR_W-1:0] snr_out_q;

	// RAM ports
	ctrl_t   ctrl_rd, ctrl_wd;
	levels_t lvl_rd, lvl_wd;
	logic    ctrl_we, lvl_we;
	logic [AW-1:0] waddr, raddr;

	logic accept, out_free;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign raddr    = AW'(channel);

	cwenv_ram #(.WIDTH($bits(ctrl_t)), .DEPTH(CHANNELS)) u_ctrl_ram (
		.clk(clk), .we(ctrl_we), .waddr(waddr), .wdata(ctrl_wd),
		.re(accept), .raddr(raddr), .rdata(ctrl_rd)
	);

	cwenv_ram #(.WIDTH($bits(levels_t)), .DEPTH(CHANNELS)) u_lvl_ram (
		.clk(clk), .we(lvl_we), .waddr(waddr), .wdata(lvl_wd),
		.re(accept), .raddr(raddr), .rdata(lvl_rd)
	);

	// divider: two restoring steps a cycle
	logic [24:0] rem_n;
	logic [31:0] quo_n;
	logic [25:0] trial;
	always_comb begin
		rem_n = rem_q;
		quo_n = quo_q;
		trial = '0;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_n, quo_n[31]} - {2'b00, nf_q};
			if (!trial[25]) begin
				rem_n = trial[24:0];
				quo_n = {quo_n[30:0], 1'b1};
			end else begin
				rem_n = {rem_n[23:0], quo_n[31]};
				quo_n = {quo_n[30:0], 1'b0};
			end
		end
	end

	// step 1: SNR, threshold, start seeding, silence count
	logic [SNR_W-1:0] ratio, snr_c1, sdiff;
	logic [27:0]      sfall;
	logic [27:0]      mag16;
	logic [31:0]      nfthr;
	logic             key_c1, seed_c1;
	logic [CNT_W:0]   cnt_inc;
	logic [LVL_W-1:0] lo_c1, hi_c1;
	always_comb begin
		ratio = (quo_q[31:16] != '0) ? '1 : quo_q[15:0];
		sdiff = '0;
		sfall = '0;
		if (ratio >= ctrl_rd.snr) begin
			snr_c1 = ctrl_rd.snr + SNR_W'((ratio - ctrl_rd.snr) >> 2);
		end else begin
			sdiff  = ctrl_rd.snr - ratio;
			sfall  = sdiff * SNR_FALL;
			snr_c1 = ctrl_rd.snr - {4'b0, sfall[27:16]};
		end
		mag16   = {mag_q, 4'b0};
		nfthr   = nf_q * thr_q;
		key_c1  = ({4'b0, mag16} >= nfthr);
		seed_c1 = key_c1 && !ctrl_rd.started;
		lo_c1   = seed_c1 ? {1'b0, mag_q, 7'b0} : lvl_rd.lo;
		hi_c1   = seed_c1 ? {mag_q, 8'b0} : lvl_rd.hi;
		cnt_inc = {1'b0, ctrl_rd.cnt} + 1'b1;
	end

	// step 2: hysteresis offsets, decay, attack distances
	logic [LVL_W-1:0] pwr, rabs;
	logic [39:0]      upp, dnp;
	logic [47:0]      decp;
	logic [32:0]      dlo, dhi;
	always_comb begin
		pwr  = {mag_q, 8'b0};
		rabs = rng_s1[32] ? LVL_W'(-rng_s1) : rng_s1[31:0];
		upp  = rng_s1[31:0] * upf_q;
		dnp  = rng_s1[31:0] * lof_q;
		decp = rabs * dcy_q;
		dlo  = {1'b0, pwr} - {1'b0, lo_s1};
		dhi  = {1'b0, pwr} - {1'b0, hi_s1};
	end

	// step 3: envelope decision, attack products
	logic [32:0] upt, dnt;
	logic        big;
	logic [47:0] alop, ahip;
	always_comb begin
		upt  = {1'b0, lo_s1} + {1'b0, upo_s2};
		dnt  = {1'b0, lo_s1} + {1'b0, dno_s2};
		big  = !rng_s1[32] && (rng_s1[31:0] > 32'd2);
		alop = dlo_s2 * att_q;
		ahip = dhi_s2 * att_q;
	end

	// final: level update with saturation, write-back
	logic [33:0] lo_n, hi_n;
	logic [LVL_W-1:0] lo_sat, hi_sat;
	always_comb begin
		if (plo_s2) begin
			lo_n = {2'b0, lo_s1} - {2'b0, alo_s3};
		end else if (rng_s1[32]) begin
			lo_n = {2'b0, lo_s1} - {2'b0, dec_s2};
		end else begin
			lo_n = {2'b0, lo_s1} + {2'b0, dec_s2};
		end
		if (phi_s2) begin
			hi_n = {2'b0, hi_s1} + {2'b0, ahi_s3};
		end else if (rng_s1[32]) begin
			hi_n = {2'b0, hi_s1} + {2'b0, dec_s2};
		end else begin
			hi_n = {2'b0, hi_s1} - {2'b0, dec_s2};
		end
		lo_sat = lo_n[33] ? '0 : (lo_n[32] ? '1 : lo_n[31:0]);
		hi_sat = hi_n[33] ? '0 : (hi_n[32] ? '1 : hi_n[31:0]);
	end

	logic write_item;
	always_comb begin
		write_item = (state_q == ST_OUT) && out_free && inr_s1;
		waddr      = (state_q == ST_CLEAR) ? clr_q : AW'(ch_q);
		ctrl_we    = (state_q == ST_CLEAR) || write_item;
		lvl_we     = write_item && (keyed_s1 || sres_s1);
		ctrl_wd    = '0;
		lvl_wd     = '0;
		if (state_q != ST_CLEAR) begin
			ctrl_wd.env     = keyed_s1 ? env_s3 : env_old_s1;
			ctrl_wd.snr     = snr_s1;
			ctrl_wd.cnt     = cnt_s1;
			ctrl_wd.started = keyed_s1 || start_s1;
			lvl_wd.lo       = sres_s1 ? idle_q : lo_sat;
			lvl_wd.hi       = sres_s1 ? idle_q : hi_sat;
		end
	end

	// control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			thr_q       <= RST_THRESHOLD;
			sil_q       <= RST_SILENCE;
			upf_q       <= RST_UPPER;
			lof_q       <= RST_LOWER;
			att_q       <= RST_ATTACK;
			dcy_q       <= RST_DECAY;
			idle_q      <= RST_IDLE;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_THRESHOLD: thr_q  <= cfg_data[7:0];
					REG_SILENCE:   sil_q  <= cfg_data[CNT_W-1:0];
					REG_UPPER:     upf_q  <= cfg_data[7:0];
					REG_LOWER:     lof_q  <= cfg_data[7:0];
					REG_ATTACK:    att_q  <= cfg_data[15:0];
					REG_DECAY:     dcy_q  <= cfg_data[15:0];
					REG_IDLE:      idle_q <= cfg_data;
					default: ;
				endcase
			end
			// result register: loaded at write-back, emptied on transfer
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(CHANNELS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_DIV;
						div_cnt_q <= '0;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 4'd15) begin
						state_q <= ST_C1;
					end
				end
				ST_C1: state_q <= ST_C2;
				ST_C2: state_q <= ST_C3;
				ST_C3: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ch_q  <= channel;
					mag_q <= magnitude;
					nf_q  <= (noise_floor == '0) ? MAG_W'(1) : noise_floor;
					rem_q <= '0;
					quo_q <= {magnitude, 8'b0};
				end
			end
			ST_DIV: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
			end
			ST_C1: begin
				inr_s1     <= (32'(ch_q) < CHANNELS);
				keyed_s1   <= key_c1;
				start_s1   <= ctrl_rd.started;
				env_old_s1 <= ctrl_rd.env;
				lo_s1      <= lo_c1;
				hi_s1      <= hi_c1;
				rng_s1     <= {1'b0, hi_c1} - {1'b0, lo_c1};
				if (key_c1) begin
					sres_s1 <= 1'b0;
					snr_s1  <= seed_c1 ? '0 : snr_c1;
					cnt_s1  <= '0;
				end else if (ctrl_rd.started && (cnt_inc > {1'b0, sil_q})) begin
					sres_s1 <= 1'b1;
					snr_s1  <= '0;
					cnt_s1  <= '0;
				end else if (ctrl_rd.started) begin
					sres_s1 <= 1'b0;
					snr_s1  <= snr_c1;
					cnt_s1  <= cnt_inc[CNT_W-1:0];
				end else begin
					sres_s1 <= 1'b0;
					snr_s1  <= snr_c1;
					cnt_s1  <= ctrl_rd.cnt;
				end
			end
			ST_C2: begin
				upo_s2 <= upp[39:8];
				dno_s2 <= dnp[39:8];
				dec_s2 <= decp[47:16];
				plo_s2 <= dlo[32];
				phi_s2 <= !dhi[32] && (dhi[31:0] != '0);
				dlo_s2 <= dlo[32] ? LVL_W'(-dlo) : dlo[31:0];
				dhi_s2 <= dhi[31:0];
			end
			ST_C3: begin
				alo_s3 <= alop[47:16];
				ahi_s3 <= ahip[47:16];
				if (!big) begin
					env_s3 <= 1'b0;
				end else if ({1'b0, pwr} > upt) begin
					env_s3 <= 1'b1;
				end else if ({1'b0, pwr} < dnt) begin
					env_s3 <= 1'b0;
				end else begin
					env_s3 <= env_old_s1;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					ch_out_q  <= ch_q;
					keyed_q   <= inr_s1 && keyed_s1;
					env_q     <= inr_s1 && keyed_s1 && env_s3;
					snr_out_q <= inr_s1 ? snr_s1 : '0;
					start_q   <= inr_s1 && keyed_s1 && !start_s1;
					sres_q    <= inr_s1 && sres_s1;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign channel_out   = ch_out_q;
	assign keyed         = keyed_q;
	assign envelope      = env_q;
	assign snr_level     = snr_out_q;
	assign started       = start_q;
	assign silence_reset = sres_q;

endmodule
`default_nettype wire
